// ===== src/mail_transfer_client_sequencer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the mail transfer client sequencer
// Concurrent checks on the rising edge of clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MAIL_TRANSFER_CLIENT_SEQUENCER_UNIT_DEFINES_SVH
`define MAIL_TRANSFER_CLIENT_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define MTCS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define MTCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTCS_ASSERT(label, ante, cons, msg)
`define MTCS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/mtcs_pkg.sv =====
// ---------------------------------------------------------------------------
// Mail transfer client sequencer package
// Codes, session states and the structs shared by the sequencer modules.
// ---------------------------------------------------------------------------
package mtcs_pkg;

  typedef enum logic [3:0] {
    CMD_CONNECT   = 4'd0,
    CMD_LOGIN     = 4'd1,
    CMD_SEND_MAIL = 4'd2,
    CMD_QUIT      = 4'd3,
    CMD_RESET     = 4'd4,
    CMD_SOCK_UP   = 4'd5,
    CMD_SOCK_DOWN = 4'd6,
    CMD_REPLY     = 4'd7,
    CMD_ENCRYPTED = 4'd8
  } cmd_t;

  typedef enum logic [4:0] {
    ACT_NONE       = 5'd0,
    ACT_OPEN       = 5'd1,
    ACT_OPEN_ENC   = 5'd2,
    ACT_EHLO       = 5'd3,
    ACT_STARTTLS   = 5'd4,
    ACT_ENCRYPT    = 5'd5,
    ACT_AUTH_PLAIN = 5'd6,
    ACT_AUTH_LOGIN = 5'd7,
    ACT_USER       = 5'd8,
    ACT_PASS       = 5'd9,
    ACT_FROM       = 5'd10,
    ACT_RCPT       = 5'd11,
    ACT_DATA       = 5'd12,
    ACT_BODY_END   = 5'd13,
    ACT_QUIT       = 5'd14,
    ACT_RSET       = 5'd15,
    ACT_CLOSE      = 5'd16
  } act_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_READY        = 3'd1,
    EV_AUTHENTICATED = 3'd2,
    EV_MAIL_SENT    = 3'd3,
    EV_RESET_DONE   = 3'd4,
    EV_DISCONNECTED = 3'd5
  } evt_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_SERVER = 3'd1,
    ERR_CLIENT = 3'd2,
    ERR_AUTH   = 3'd3,
    ERR_MAIL   = 3'd4,
    ERR_SOCKET = 3'd5
  } err_t;

  // Session states, one-hot. Passing steps of the protocol have no state.
  typedef enum logic [18:0] {
    S_UNCONNECTED   = 19'h00001,
    S_CONNECTING    = 19'h00002,
    S_CONNECTED     = 19'h00004,
    S_READY         = 19'h00008,
    S_DISCONNECTING = 19'h00010,
    S_RESET         = 19'h00020,
    S_EHLO          = 19'h00040,
    S_TLS_START     = 19'h00080,
    S_TLS_ENCRYPT   = 19'h00100,
    S_TLS_EHLO      = 19'h00200,
    S_AUTH_PLAIN    = 19'h00400,
    S_AUTH_LOGIN    = 19'h00800,
    S_LOGIN_USER    = 19'h01000,
    S_LOGIN_PASS    = 19'h02000,
    S_MAIL_FROM     = 19'h04000,
    S_RCPT          = 19'h08000,
    S_DATA          = 19'h10000,
    S_SEND_DATA     = 19'h20000,
    S_QUITTING      = 19'h40000
  } state_t;

  // Register map: word index within the configuration window.
  localparam logic REG_LINK_MODE = 1'b0;
  localparam logic REG_AUTH_MODE = 1'b1;

  localparam logic [1:0] LINK_TLS      = 2'd1;
  localparam logic [1:0] LINK_STARTTLS = 2'd2;
  localparam logic       AUTH_TWO_STEP = 1'b1;

  // Server reply codes the session waits for.
  localparam logic [9:0] CODE_GREETING  = 10'd220;
  localparam logic [9:0] CODE_OK        = 10'd250;
  localparam logic [9:0] CODE_BYE       = 10'd221;
  localparam logic [9:0] CODE_AUTH_OK   = 10'd235;
  localparam logic [9:0] CODE_CHALLENGE = 10'd334;
  localparam logic [9:0] CODE_DATA_GO   = 10'd354;

  localparam logic [1:0] KIND_DONE = 2'd3;

  // Session context kept between requests.
  typedef struct packed {
    state_t          state;
    logic            ready;
    logic            auth;
    logic            sent;
    logic [1:0]      kind;
    logic [7:0]      pos;
    logic [2:0][7:0] sizes;
  } ctx_t;

  // One result.
  typedef struct packed {
    act_t       action;
    logic [1:0] rcpt_kind;
    logic [7:0] rcpt_index;
    evt_t       event_res;
    err_t       error;
    logic [4:0] state_code;
  } res_t;

  // Externally visible number of a session state.
  function automatic logic [4:0] state_code(state_t s);
    logic [4:0] c;
    unique case (s)
      S_UNCONNECTED:   c = 5'd0;
      S_CONNECTING:    c = 5'd1;
      S_CONNECTED:     c = 5'd2;
      S_READY:         c = 5'd3;
      S_DISCONNECTING: c = 5'd6;
      S_RESET:         c = 5'd7;
      S_EHLO:          c = 5'd8;
      S_TLS_START:     c = 5'd11;
      S_TLS_ENCRYPT:   c = 5'd12;
      S_TLS_EHLO:      c = 5'd13;
      S_AUTH_PLAIN:    c = 5'd15;
      S_AUTH_LOGIN:    c = 5'd16;
      S_LOGIN_USER:    c = 5'd17;
      S_LOGIN_PASS:    c = 5'd18;
      S_MAIL_FROM:     c = 5'd20;
      S_RCPT:          c = 5'd22;
      S_DATA:          c = 5'd23;
      S_SEND_DATA:     c = 5'd24;
      S_QUITTING:      c = 5'd26;
      default:         c = 5'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== src/mtcs_core.sv =====
// ---------------------------------------------------------------------------
// Mail transfer client sequencer decision logic
// Computes the next session context and the result for one request.
// ---------------------------------------------------------------------------
module mtcs_core import mtcs_pkg::*; #(
  parameter logic [7:0] CNT_LIMIT = 8'd255
) (
  input  ctx_t       ctx,
  input  logic [1:0] link_mode,
  input  logic       auth_mode,
  input  logic [3:0] command,
  input  logic [9:0] reply_code,
  input  logic [7:0] to_count,
  input  logic [7:0] cc_count,
  input  logic [7:0] bcc_count,
  input  logic       sock_failed,
  output ctx_t       ctx_nxt,
  output res_t       res
);

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
    logic [7:0] index;
    logic [1:0] next_kind;
    logic [7:0] next_pos;
  } rstep_t;

  // Finds the next recipient at or after (kind, pos), skipping empty lists.
  function automatic rstep_t next_rcpt(logic [1:0] kind, logic [7:0] pos,
                                       logic [2:0][7:0] sizes);
    rstep_t     r;
    logic [7:0] p;
    r = '0;
    r.next_kind = KIND_DONE;
    for (int j = 0; j < 3; j++) begin
      p = (int'(kind) == j) ? pos : 8'd0;
      if (!r.hit && (int'(kind) <= j) && (p < sizes[j])) begin
        r.hit       = 1'b1;
        r.kind      = 2'(j);
        r.index     = p;
        r.next_kind = 2'(j);
        r.next_pos  = 8'(p + 8'd1);
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp(logic [7:0] c);
    return (c > CNT_LIMIT) ? CNT_LIMIT : c;
  endfunction

  rstep_t rstep;
  logic   cls_server;
  logic   cls_client;

  // A new mail starts the recipient walk from the first list.
  assign rstep = (ctx.state == S_MAIL_FROM) ? next_rcpt(2'd0, 8'd0, ctx.sizes)
                                            : next_rcpt(ctx.kind, ctx.pos, ctx.sizes);
  assign cls_server = (reply_code >= 10'd400) && (reply_code <= 10'd499);
  assign cls_client = (reply_code >= 10'd500) && (reply_code <= 10'd599);

  always_comb begin
    ctx_nxt = ctx;
    res     = '0;
    if (sock_failed) begin
      res.error = ERR_SOCKET;
    end else begin
      unique case (command)
        CMD_CONNECT: begin
          if (ctx.state == S_UNCONNECTED) begin
            ctx_nxt.state = S_CONNECTING;
            res.action    = (link_mode == LINK_TLS) ? ACT_OPEN_ENC : ACT_OPEN;
          end
        end
        CMD_LOGIN: begin
          if (ctx.ready && !ctx.auth) begin
            if (auth_mode == AUTH_TWO_STEP) begin
              ctx_nxt.state = S_AUTH_LOGIN;
              res.action    = ACT_AUTH_LOGIN;
            end else begin
              ctx_nxt.state = S_AUTH_PLAIN;
              res.action    = ACT_AUTH_PLAIN;
            end
          end
        end
        CMD_SEND_MAIL: begin
          if (ctx.ready) begin
            ctx_nxt.sent     = 1'b0;
            ctx_nxt.kind     = 2'd0;
            ctx_nxt.pos      = 8'd0;
            ctx_nxt.sizes[0] = clamp(to_count);
            ctx_nxt.sizes[1] = clamp(cc_count);
            ctx_nxt.sizes[2] = clamp(bcc_count);
            ctx_nxt.state    = S_MAIL_FROM;
            res.action       = ACT_FROM;
          end
        end
        CMD_QUIT: begin
          ctx_nxt.state = S_QUITTING;
          res.action    = ACT_QUIT;
        end
        CMD_RESET: begin
          if (ctx.ready) begin
            ctx_nxt.state = S_RESET;
            res.action    = ACT_RSET;
          end
        end
        CMD_SOCK_UP: begin
          ctx_nxt.state = S_CONNECTED;
        end
        CMD_SOCK_DOWN: begin
          ctx_nxt.state = S_UNCONNECTED;
          ctx_nxt.ready = 1'b0;
          ctx_nxt.auth  = 1'b0;
          res.event_res = EV_DISCONNECTED;
        end
        CMD_ENCRYPTED: begin
          if (ctx.state == S_TLS_ENCRYPT) begin
            ctx_nxt.state = S_TLS_EHLO;
            res.action    = ACT_EHLO;
          end
        end
        CMD_REPLY: begin
          priority if (cls_server) begin
            res.error = ERR_SERVER;
          end else if (cls_client) begin
            res.error = ERR_CLIENT;
          end else begin
            unique case (ctx.state)
              S_CONNECTED: begin
                if (reply_code != CODE_GREETING) res.error = ERR_SERVER;
                else begin
                  ctx_nxt.state = S_EHLO;
                  res.action    = ACT_EHLO;
                end
              end
              S_RESET: begin
                if (reply_code != CODE_OK) res.error = ERR_SERVER;
                else begin
                  ctx_nxt.state = S_READY;
                  res.event_res = EV_RESET_DONE;
                end
              end
              S_EHLO: begin
                if (reply_code != CODE_OK) res.error = ERR_SERVER;
                else if (link_mode == LINK_STARTTLS) begin
                  ctx_nxt.state = S_TLS_START;
                  res.action    = ACT_STARTTLS;
                end else begin
                  ctx_nxt.state = S_READY;
                  ctx_nxt.ready = 1'b1;
                  res.event_res = EV_READY;
                end
              end
              S_QUITTING: begin
                if (reply_code != CODE_BYE) res.error = ERR_CLIENT;
                else begin
                  ctx_nxt.state = S_DISCONNECTING;
                  ctx_nxt.ready = 1'b0;
                  res.action    = ACT_CLOSE;
                end
              end
              S_TLS_START: begin
                if (reply_code != CODE_GREETING) res.error = ERR_SERVER;
                else begin
                  ctx_nxt.state = S_TLS_ENCRYPT;
                  res.action    = ACT_ENCRYPT;
                end
              end
              S_TLS_EHLO: begin
                if (reply_code != CODE_OK) res.error = ERR_SERVER;
                else begin
                  ctx_nxt.state = S_READY;
                  ctx_nxt.ready = 1'b1;
                  res.event_res = EV_READY;
                end
              end
              S_AUTH_PLAIN, S_LOGIN_PASS: begin
                if (reply_code != CODE_AUTH_OK) res.error = ERR_AUTH;
                else begin
                  ctx_nxt.state = S_READY;
                  ctx_nxt.auth  = 1'b1;
                  res.event_res = EV_AUTHENTICATED;
                end
              end
              S_AUTH_LOGIN: begin
                if (reply_code != CODE_CHALLENGE) res.error = ERR_AUTH;
                else begin
                  ctx_nxt.state = S_LOGIN_USER;
                  res.action    = ACT_USER;
                end
              end
              S_LOGIN_USER: begin
                if (reply_code != CODE_CHALLENGE) res.error = ERR_AUTH;
                else begin
                  ctx_nxt.state = S_LOGIN_PASS;
                  res.action    = ACT_PASS;
                end
              end
              S_MAIL_FROM, S_RCPT: begin
                if (reply_code != CODE_OK) res.error = ERR_MAIL;
                else begin
                  ctx_nxt.kind = rstep.next_kind;
                  ctx_nxt.pos  = rstep.next_pos;
                  if (rstep.hit) begin
                    ctx_nxt.state  = S_RCPT;
                    res.action     = ACT_RCPT;
                    res.rcpt_kind  = rstep.kind;
                    res.rcpt_index = rstep.index;
                  end else begin
                    ctx_nxt.state = S_DATA;
                    res.action    = ACT_DATA;
                  end
                end
              end
              S_DATA: begin
                if (reply_code != CODE_DATA_GO) res.error = ERR_MAIL;
                else begin
                  ctx_nxt.state = S_SEND_DATA;
                  res.action    = ACT_BODY_END;
                end
              end
              S_SEND_DATA: begin
                if (reply_code != CODE_OK) res.error = ERR_MAIL;
                else begin
                  ctx_nxt.state = S_READY;
                  ctx_nxt.sent  = 1'b1;
                  res.event_res = EV_MAIL_SENT;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
    res.state_code = state_code(ctx_nxt.state);
  end

endmodule

// ===== src/mail_transfer_client_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// Mail transfer client sequencer
// Session control for the client side of a mail transfer exchange.
// ---------------------------------------------------------------------------
// Each request on the in_ channel carries one event: a user command, a socket
// notice or a parsed three-digit server reply. For every request the block
// returns exactly one result on the out_ channel: the action to perform, the
// recipient position for a recipient action, a completion event, an error
// code and the session state after the event.
// A request is taken into the input register at the edge where in_valid is
// high and in_stall is low. The decision logic resolves it against the session
// context and loads the result register when that register is free or being
// emptied; the result then shows on out_valid. One request per cycle is
// sustained while out_stall is low; the rate is set by the session context
// register, which is read and written once per request. When out_stall holds
// the result register, one further request can still be taken into the input
// register; only then does in_stall rise. Synchronous reset (rst_n low)
// empties both registers, returns the session to the unconnected state and
// clears the link and login mode registers. link_mode (offset 0x0) and
// auth_mode (offset 0x4) are written over the APB port; the user must write
// them only while idle (the block does not enforce it); pready is always high.
`include "mail_transfer_client_sequencer_unit_defines.svh"

module mail_transfer_client_sequencer_unit import mtcs_pkg::*; #(
  parameter int RECIPIENT_COUNT_MAX = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_command,
  input  logic [9:0]  in_reply_code,
  input  logic [7:0]  in_to_count,
  input  logic [7:0]  in_cc_count,
  input  logic [7:0]  in_bcc_count,
  input  logic        in_sock_failed,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_action,
  output logic [1:0]  out_rcpt_kind,
  output logic [7:0]  out_rcpt_index,
  output logic [2:0]  out_event_res,
  output logic [2:0]  out_error,
  output logic [4:0]  out_session_state,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Counts are 8 bits wide, so a limit above 255 never clips.
  localparam logic [7:0] CNT_LIMIT =
    (RECIPIENT_COUNT_MAX > 255) ? 8'd255 : 8'(RECIPIENT_COUNT_MAX);

  // Configuration registers.
  logic [1:0] link_mode_r, link_mode_nxt;
  logic       auth_mode_r, auth_mode_nxt;
  logic       cfg_wr;

  // Input register.
  logic       in_vld_r, in_vld_nxt;
  logic [3:0] cmd_r;
  logic [9:0] code_r;
  logic [7:0] to_r, cc_r, bcc_r;
  logic       fail_r;
  logic       in_take;

  // Session context and result register.
  ctx_t ctx_r, ctx_nxt;
  res_t res_calc;
  res_t out_res_r;
  logic out_vld_r, out_vld_nxt;
  logic advance;

  // ---- Configuration port -------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    link_mode_nxt = link_mode_r;
    auth_mode_nxt = auth_mode_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_LINK_MODE: link_mode_nxt = pwdata[1:0];
        REG_AUTH_MODE: auth_mode_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LINK_MODE: prdata = {30'd0, link_mode_r};
      REG_AUTH_MODE: prdata = {31'd0, auth_mode_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_mode_r <= 2'd0;
      auth_mode_r <= 1'b0;
    end else begin
      link_mode_r <= link_mode_nxt;
      auth_mode_r <= auth_mode_nxt;
    end
  end

  // ---- Flow control -------------------------------------------------------
  // The held request moves on whenever the result register is free or
  // being emptied this cycle.
  assign advance     = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall    = in_vld_r & ~advance;
  assign in_take     = in_valid & ~in_stall;
  assign in_vld_nxt  = in_take | (in_vld_r & ~advance);
  assign out_vld_nxt = advance | (out_vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= in_command;
      code_r <= in_reply_code;
      to_r   <= in_to_count;
      cc_r   <= in_cc_count;
      bcc_r  <= in_bcc_count;
      fail_r <= in_sock_failed;
    end
  end

  // ---- Decision logic -----------------------------------------------------
  mtcs_core #(
    .CNT_LIMIT (CNT_LIMIT)
  ) u_core (
    .ctx         (ctx_r),
    .link_mode   (link_mode_r),
    .auth_mode   (auth_mode_r),
    .command     (cmd_r),
    .reply_code  (code_r),
    .to_count    (to_r),
    .cc_count    (cc_r),
    .bcc_count   (bcc_r),
    .sock_failed (fail_r),
    .ctx_nxt     (ctx_nxt),
    .res         (res_calc)
  );

  // The context only moves together with the result register, so a result
  // waiting under stall always matches the context it left behind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state <= S_UNCONNECTED;
      ctx_r.ready <= 1'b0;
      ctx_r.auth  <= 1'b0;
      ctx_r.sent  <= 1'b0;
      ctx_r.kind  <= 2'd0;
      ctx_r.pos   <= 8'd0;
      ctx_r.sizes <= '0;
    end else if (advance) begin
      ctx_r <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_calc;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_action        = out_res_r.action;
  assign out_rcpt_kind     = out_res_r.rcpt_kind;
  assign out_rcpt_index    = out_res_r.rcpt_index;
  assign out_event_res     = out_res_r.event_res;
  assign out_error         = out_res_r.error;
  assign out_session_state = out_res_r.state_code;

  // ---- Checks -------------------------------------------------------------
  `MTCS_ASSERT(a_state_onehot, 1'b1, $onehot(ctx_r.state), "session state not one-hot")
  `MTCS_ASSERT(a_err_quiet, out_vld_r && (out_res_r.error != ERR_NONE), (out_res_r.action == ACT_NONE) && (out_res_r.event_res == EV_NONE), "error result carries an action or event")
  `MTCS_ASSERT(a_rcpt_state, out_vld_r && (out_res_r.action == ACT_RCPT), ctx_r.state == S_RCPT, "recipient action outside recipient state")
  `MTCS_ASSERT(a_walk_done, ctx_r.kind == KIND_DONE, ctx_r.pos == 8'd0, "finished recipient walk keeps a position")
  `MTCS_ASSERT(a_ready_flag, out_vld_r && (out_res_r.event_res == EV_READY), ctx_r.ready, "ready event without ready flag")

endmodule

// ===== verif/mail_transfer_client_sequencer_unit_test.sv =====
// ---------------------------------------------------------------------------
// Mail transfer client sequencer testbench
// Drives session events into the sequencer and checks every result against
// a cycle-free model of the session in this bench, or a hand-typed result.
// ---------------------------------------------------------------------------
module mail_transfer_client_sequencer_unit_test import mtcs_pkg::*;;

  // Session state numbers as they show on out_session_state.
  typedef enum logic [4:0] {
    SS_UNCONNECTED   = 5'd0,
    SS_CONNECTING    = 5'd1,
    SS_CONNECTED     = 5'd2,
    SS_READY         = 5'd3,
    SS_DISCONNECTING = 5'd6,
    SS_RESET         = 5'd7,
    SS_EHLO          = 5'd8,
    SS_TLS_START     = 5'd11,
    SS_TLS_ENCRYPT   = 5'd12,
    SS_TLS_EHLO      = 5'd13,
    SS_AUTH_PLAIN    = 5'd15,
    SS_AUTH_LOGIN    = 5'd16,
    SS_LOGIN_USER    = 5'd17,
    SS_LOGIN_PASS    = 5'd18,
    SS_MAIL_FROM     = 5'd20,
    SS_RCPT          = 5'd22,
    SS_DATA          = 5'd23,
    SS_SEND_DATA     = 5'd24,
    SS_QUITTING      = 5'd26
  } sess_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic [9:0] code;
    logic [7:0] to_n;
    logic [7:0] cc_n;
    logic [7:0] bcc_n;
    logic       fail;
  } request_t;

  typedef struct packed {
    act_t       action;
    logic [1:0] kind;
    logic [7:0] index;
    evt_t       ev;
    err_t       err;
    sess_t      st;
  } session_result_t;

  // One row of the directed sequence. Rows marked TYPED carry a result that
  // was written down by hand; the others take the result of the predictor.
  typedef struct packed {
    request_t        rq;
    bit              fixed;
    session_result_t res;
  } script_row_t;

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  // The highest command code; everything above CMD_ENCRYPTED is undefined.
  localparam logic [3:0] CMD_UNDEFINED_MAX = 4'd15;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 6;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [3:0]  in_command     = '0;
  logic [9:0]  in_reply_code  = '0;
  logic [7:0]  in_to_count    = '0;
  logic [7:0]  in_cc_count    = '0;
  logic [7:0]  in_bcc_count   = '0;
  logic        in_sock_failed = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [4:0]  out_action;
  logic [1:0]  out_rcpt_kind;
  logic [7:0]  out_rcpt_index;
  logic [2:0]  out_event_res;
  logic [2:0]  out_error;
  logic [4:0]  out_session_state;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  mail_transfer_client_sequencer_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_reply_code     (in_reply_code),
    .in_to_count       (in_to_count),
    .in_cc_count       (in_cc_count),
    .in_bcc_count      (in_bcc_count),
    .in_sock_failed    (in_sock_failed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_rcpt_kind     (out_rcpt_kind),
    .out_rcpt_index    (out_rcpt_index),
    .out_event_res     (out_event_res),
    .out_error         (out_error),
    .out_session_state (out_session_state),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow copy of the session context and of the two mode registers.
  logic [1:0] link_q  = '0;
  logic       auth_q  = 1'b0;
  sess_t      sess    = SS_UNCONNECTED;
  logic       ready_q = 1'b0;
  logic       authed  = 1'b0;
  logic       sent_q  = 1'b0;
  logic [1:0] kind_q  = '0;
  logic [7:0] pos_q   = '0;
  logic [7:0] sizes_q [3] = '{8'd0, 8'd0, 8'd0};

  session_result_t pending_results [$];
  session_result_t want;
  script_row_t     script [$];

  int faults     = 0;
  int sent_n     = 0;
  int checked_n  = 0;
  int ignored_n  = 0;
  int mails_n    = 0;
  int rcpt_n     = 0;
  int burst_left = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int idle_n     = 0;

  // Applies one event to the shadow session and returns the result that the
  // block has to produce for it. Transient steps collapse into the same call,
  // just as the block resolves them within one request.
  function automatic session_result_t step_session(request_t rq);
    session_result_t o;
    logic            walk;
    o    = '0;
    walk = 1'b0;
    if (rq.fail) begin
      // A socket failure masks whatever command came with it.
      o.err = ERR_SOCKET;
    end else begin
      case (rq.cmd)
        CMD_CONNECT: if (sess == SS_UNCONNECTED) begin
          sess     = SS_CONNECTING;
          o.action = (link_q == LINK_TLS) ? ACT_OPEN_ENC : ACT_OPEN;
        end
        CMD_LOGIN: if (ready_q && !authed) begin
          if (auth_q == AUTH_TWO_STEP) begin
            sess     = SS_AUTH_LOGIN;
            o.action = ACT_AUTH_LOGIN;
          end else begin
            sess     = SS_AUTH_PLAIN;
            o.action = ACT_AUTH_PLAIN;
          end
        end
        CMD_SEND_MAIL: if (ready_q) begin
          // Counts are 8 bits wide, so the 255 ceiling never bites.
          sent_q     = 1'b0;
          kind_q     = '0;
          pos_q      = '0;
          sizes_q[0] = rq.to_n;
          sizes_q[1] = rq.cc_n;
          sizes_q[2] = rq.bcc_n;
          sess       = SS_MAIL_FROM;
          o.action   = ACT_FROM;
        end
        CMD_QUIT: begin
          sess     = SS_QUITTING;
          o.action = ACT_QUIT;
        end
        CMD_RESET: if (ready_q) begin
          sess     = SS_RESET;
          o.action = ACT_RSET;
        end
        CMD_SOCK_UP: sess = SS_CONNECTED;
        CMD_SOCK_DOWN: begin
          sess    = SS_UNCONNECTED;
          ready_q = 1'b0;
          authed  = 1'b0;
          o.ev    = EV_DISCONNECTED;
        end
        CMD_ENCRYPTED: if (sess == SS_TLS_ENCRYPT) begin
          sess     = SS_TLS_EHLO;
          o.action = ACT_EHLO;
        end
        CMD_REPLY: begin
          // Temporary and permanent failure classes win over the step.
          if (rq.code / 100 == 4) o.err = ERR_SERVER;
          else if (rq.code / 100 == 5) o.err = ERR_CLIENT;
          else begin
            case (sess)
              SS_CONNECTED: if (rq.code != CODE_GREETING) o.err = ERR_SERVER;
              else begin
                sess     = SS_EHLO;
                o.action = ACT_EHLO;
              end
              SS_RESET: if (rq.code != CODE_OK) o.err = ERR_SERVER;
              else begin
                sess = SS_READY;
                o.ev = EV_RESET_DONE;
              end
              SS_EHLO: if (rq.code != CODE_OK) o.err = ERR_SERVER;
              else if (link_q == LINK_STARTTLS) begin
                sess     = SS_TLS_START;
                o.action = ACT_STARTTLS;
              end else begin
                ready_q = 1'b1;
                sess    = SS_READY;
                o.ev    = EV_READY;
              end
              SS_QUITTING: if (rq.code != CODE_BYE) o.err = ERR_CLIENT;
              else begin
                sess     = SS_DISCONNECTING;
                o.action = ACT_CLOSE;
                ready_q  = 1'b0;
              end
              SS_TLS_START: if (rq.code != CODE_GREETING) o.err = ERR_SERVER;
              else begin
                sess     = SS_TLS_ENCRYPT;
                o.action = ACT_ENCRYPT;
              end
              SS_TLS_EHLO: if (rq.code != CODE_OK) o.err = ERR_SERVER;
              else begin
                ready_q = 1'b1;
                sess    = SS_READY;
                o.ev    = EV_READY;
              end
              SS_AUTH_PLAIN, SS_LOGIN_PASS: if (rq.code != CODE_AUTH_OK) o.err = ERR_AUTH;
              else begin
                authed = 1'b1;
                sess   = SS_READY;
                o.ev   = EV_AUTHENTICATED;
              end
              SS_AUTH_LOGIN: if (rq.code != CODE_CHALLENGE) o.err = ERR_AUTH;
              else begin
                sess     = SS_LOGIN_USER;
                o.action = ACT_USER;
              end
              SS_LOGIN_USER: if (rq.code != CODE_CHALLENGE) o.err = ERR_AUTH;
              else begin
                sess     = SS_LOGIN_PASS;
                o.action = ACT_PASS;
              end
              SS_MAIL_FROM: if (rq.code != CODE_OK) o.err = ERR_MAIL;
              else begin
                kind_q = '0;
                pos_q  = '0;
                walk   = 1'b1;
              end
              SS_RCPT: if (rq.code != CODE_OK) o.err = ERR_MAIL;
              else walk = 1'b1;
              SS_DATA: if (rq.code != CODE_DATA_GO) o.err = ERR_MAIL;
              else begin
                sess     = SS_SEND_DATA;
                o.action = ACT_BODY_END;
              end
              SS_SEND_DATA: if (rq.code != CODE_OK) o.err = ERR_MAIL;
              else begin
                sent_q = 1'b1;
                sess   = SS_READY;
                o.ev   = EV_MAIL_SENT;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
    // Next recipient: skip exhausted or empty lists, then go to data.
    if (walk) begin
      while (kind_q != KIND_DONE && pos_q >= sizes_q[kind_q]) begin
        kind_q = kind_q + 2'd1;
        pos_q  = '0;
      end
      if (kind_q == KIND_DONE) begin
        sess     = SS_DATA;
        o.action = ACT_DATA;
      end else begin
        sess     = SS_RCPT;
        o.action = ACT_RCPT;
        o.kind   = kind_q;
        o.index  = pos_q;
        pos_q    = pos_q + 8'd1;
      end
    end
    o.st = sess;
    return o;
  endfunction

  // A reply code that the current step is not waiting for, or any code at
  // all: failure classes, the whole 10-bit range, and the codes that other
  // steps wait for.
  function automatic logic [9:0] stray_code();
    case ($urandom_range(0, 8))
      0: return 10'($urandom_range(400, 499));
      1: return 10'($urandom_range(500, 599));
      2, 3: return 10'($urandom_range(0, 1023));
      4: return CODE_GREETING;
      5: return CODE_OK;
      6: return CODE_BYE;
      7: return CODE_CHALLENGE;
      default: return ($urandom_range(0, 1) == 0) ? CODE_AUTH_OK : CODE_DATA_GO;
    endcase
  endfunction

  // Mostly the next request of a well-formed session for the current step,
  // with random content; the rest is noise with every field random.
  function automatic request_t pick_request();
    request_t   rq;
    int         roll;
    logic [7:0] big;
    rq.cmd   = 4'($urandom_range(0, 15));
    rq.code  = stray_code();
    rq.to_n  = 8'($urandom_range(0, 255));
    rq.cc_n  = 8'($urandom_range(0, 255));
    rq.bcc_n = 8'($urandom_range(0, 255));
    rq.fail  = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 99) < 18) return rq;
    rq.fail = 1'b0;
    case (sess)
      SS_UNCONNECTED:   rq.cmd = CMD_CONNECT;
      SS_CONNECTING:    rq.cmd = CMD_SOCK_UP;
      SS_TLS_ENCRYPT:   rq.cmd = CMD_ENCRYPTED;
      SS_DISCONNECTING: rq.cmd = CMD_SOCK_DOWN;
      SS_READY: begin
        roll = $urandom_range(0, 99);
        if (!authed && roll < 40) rq.cmd = CMD_LOGIN;
        else if (roll < 80) begin
          rq.cmd   = CMD_SEND_MAIL;
          rq.to_n  = 8'($urandom_range(0, 3));
          rq.cc_n  = 8'($urandom_range(0, 3));
          rq.bcc_n = 8'($urandom_range(0, 3));
          // Now and then one list is long, up to the full 255 entries.
          if ($urandom_range(0, 49) == 0) begin
            big = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(4, 254));
            case ($urandom_range(0, 2))
              0: rq.to_n = big;
              1: rq.cc_n = big;
              default: rq.bcc_n = big;
            endcase
          end
        end
        else if (roll < 92) rq.cmd = CMD_RESET;
        else rq.cmd = CMD_QUIT;
      end
      default: begin
        rq.cmd = CMD_REPLY;
        case (sess)
          SS_CONNECTED, SS_TLS_START:   rq.code = CODE_GREETING;
          SS_AUTH_PLAIN, SS_LOGIN_PASS: rq.code = CODE_AUTH_OK;
          SS_AUTH_LOGIN, SS_LOGIN_USER: rq.code = CODE_CHALLENGE;
          SS_DATA:                      rq.code = CODE_DATA_GO;
          SS_QUITTING:                  rq.code = CODE_BYE;
          default:                      rq.code = CODE_OK;
        endcase
        // Occasionally the server answers with something unexpected.
        if ($urandom_range(0, 99) < 7) rq.code = stray_code();
      end
    endcase
    return rq;
  endfunction

  function automatic void add_row(logic [3:0] cmd, logic [9:0] code, logic [7:0] to_n,
                                  logic [7:0] cc_n, logic [7:0] bcc_n, logic fail,
                                  bit fixed, act_t a = ACT_NONE, evt_t e = EV_NONE,
                                  err_t r = ERR_NONE, sess_t s = SS_UNCONNECTED);
    script_row_t row;
    row            = '0;
    row.rq.cmd     = cmd;
    row.rq.code    = code;
    row.rq.to_n    = to_n;
    row.rq.cc_n    = cc_n;
    row.rq.bcc_n   = bcc_n;
    row.rq.fail    = fail;
    row.fixed      = fixed;
    row.res.action = a;
    row.res.ev     = e;
    row.res.err    = r;
    row.res.st     = s;
    script.push_back(row);
  endfunction

  task automatic log_fault(string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endtask

  // Sends one request. The sender works in bursts: when a burst runs out it
  // may drop in_valid for a random gap before the next one starts. The
  // payload is held until the request is accepted, and the expected result
  // is queued at the acceptance edge.
  task automatic issue(input request_t rq, input bit fixed, input session_result_t fixed_res,
                       output bit effective);
    int              gap;
    sess_t           prior;
    session_result_t o;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_command     <= rq.cmd;
    in_reply_code  <= rq.code;
    in_to_count    <= rq.to_n;
    in_cc_count    <= rq.cc_n;
    in_bcc_count   <= rq.bcc_n;
    in_sock_failed <= rq.fail;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    prior = sess;
    o = step_session(rq);
    pending_results.push_back(fixed ? fixed_res : o);
    effective = (o.action != ACT_NONE) || (o.ev != EV_NONE) || (o.err != ERR_NONE) ||
                (sess != prior);
    sent_n++;
    if (!effective) ignored_n++;
    if (o.action == ACT_RCPT) rcpt_n++;
    if (o.ev == EV_MAIL_SENT) mails_n++;
  endtask

  // Drops in_valid and waits until every queued result has come back, then
  // waits a further settling time for the pipeline to drain.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The receiver changes its stall rate at random intervals: stretches
  // with no stall at all, light and heavy back-pressure.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Result checker: every accepted result is matched against the oldest
  // expected one, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        log_fault($sformatf("result with nothing pending: action %0d event %0d error %0d state %0d",
                            out_action, out_event_res, out_error, out_session_state));
      end else begin
        want = pending_results.pop_front();
        checked_n++;
        if (out_action !== want.action || out_rcpt_kind !== want.kind ||
            out_rcpt_index !== want.index || out_event_res !== want.ev ||
            out_error !== want.err || out_session_state !== want.st) begin
          log_fault($sformatf({"mismatch on result %0d: action %0d/%0d kind %0d/%0d ",
                               "index %0d/%0d event %0d/%0d error %0d/%0d state %0d/%0d ",
                               "(expected/actual)"},
                              checked_n, want.action, out_action, want.kind, out_rcpt_kind,
                              want.index, out_rcpt_index, want.ev, out_event_res,
                              want.err, out_error, want.st, out_session_state));
        end
      end
    end
  end

  // Watchdog: too long with no request, result or register access taken
  // means the block has hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_n = 0;
    else idle_n++;
    if (idle_n >= IDLE_LIMIT) begin
      $display("mail_transfer_client_sequencer_unit_test: done, errors");
      $finish;
    end
  end

  initial begin
    request_t        rq;
    bit              effective;
    int              done_n;
    logic [1:0]      link_sel;
    logic            auth_sel;
    session_result_t unused;
    unused = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed session with plain TCP and single-step login, as after reset.
    // Replies and commands that the session must ignore come first.
    add_row(CMD_REPLY, 10'd0, 8'd0, 8'd0, 8'd0, 1'b0, TYPED);
    add_row(CMD_CONNECT, 10'd0, 8'd0, 8'd0, 8'd0, 1'b1, TYPED,
            ACT_NONE, EV_NONE, ERR_SOCKET, SS_UNCONNECTED);
    add_row(CMD_LOGIN, 10'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_UNDEFINED_MAX, 10'd1023, 8'd255, 8'd255, 8'd255, 1'b0, TYPED);
    add_row(CMD_CONNECT, 10'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_SOCK_UP, 10'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    // Failure classes and a wrong greeting keep the connected state.
    add_row(CMD_REPLY, 10'd450, 8'd0, 8'd0, 8'd0, 1'b0, TYPED,
            ACT_NONE, EV_NONE, ERR_SERVER, SS_CONNECTED);
    add_row(CMD_REPLY, 10'd599, 8'd0, 8'd0, 8'd0, 1'b0, TYPED,
            ACT_NONE, EV_NONE, ERR_CLIENT, SS_CONNECTED);
    add_row(CMD_REPLY, CODE_BYE, 8'd0, 8'd0, 8'd0, 1'b0, TYPED,
            ACT_NONE, EV_NONE, ERR_SERVER, SS_CONNECTED);
    add_row(CMD_REPLY, CODE_GREETING, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_REPLY, CODE_OK, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    // A mail with an empty cc list, which the recipient walk must skip.
    add_row(CMD_SEND_MAIL, 10'd0, 8'd1, 8'd0, 8'd1, 1'b0, PREDICTED);
    add_row(CMD_REPLY, CODE_DATA_GO, 8'd0, 8'd0, 8'd0, 1'b0, TYPED,
            ACT_NONE, EV_NONE, ERR_MAIL, SS_MAIL_FROM);
    add_row(CMD_REPLY, CODE_OK, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_REPLY, CODE_OK, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_REPLY, CODE_OK, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_REPLY, CODE_DATA_GO, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_REPLY, CODE_OK, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    // Login, a wrong challenge, success, then a refused second login.
    add_row(CMD_LOGIN, 10'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_REPLY, CODE_CHALLENGE, 8'd0, 8'd0, 8'd0, 1'b0, TYPED,
            ACT_NONE, EV_NONE, ERR_AUTH, SS_AUTH_PLAIN);
    add_row(CMD_REPLY, CODE_AUTH_OK, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_LOGIN, 10'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    // Quit: the top code of the field is a wrong answer, then goodbye.
    add_row(CMD_QUIT, 10'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_REPLY, 10'd1023, 8'd0, 8'd0, 8'd0, 1'b0, TYPED,
            ACT_NONE, EV_NONE, ERR_CLIENT, SS_QUITTING);
    add_row(CMD_REPLY, CODE_BYE, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);
    add_row(CMD_SOCK_DOWN, 10'd0, 8'd0, 8'd0, 8'd0, 1'b0, PREDICTED);

    foreach (script[i]) issue(script[i].rq, script[i].fixed, script[i].res, effective);

    // Random sessions, one phase per combination of link and login mode.
    // The modes are only changed once the block has drained.
    for (int phase = 0; phase < PHASES; phase++) begin
      quiesce();
      link_sel = 2'(phase);
      auth_sel = phase[2];
      write_reg({REG_LINK_MODE, 2'b00}, {30'($urandom), link_sel});
      write_reg({REG_AUTH_MODE, 2'b00}, {31'($urandom), auth_sel});
      link_q = link_sel;
      auth_q = auth_sel;
      done_n = 0;
      while (done_n < ITEMS_PER_PHASE) begin
        rq = pick_request();
        issue(rq, PREDICTED, unused, effective);
        if (effective) done_n++;
      end
    end

    quiesce();
    if (pending_results.size() != 0)
      log_fault($sformatf("%0d results never arrived", pending_results.size()));
    $display("Covered %0d requests (%0d refused or ignored) over %0d mode settings.",
             sent_n, ignored_n, PHASES);
    $display("Checked %0d results; %0d mails went out with %0d recipient steps.",
             checked_n, mails_n, rcpt_n);
    if (faults == 0) begin
      $display("mail_transfer_client_sequencer_unit_test: done, clean");
    end else begin
      $display("mail_transfer_client_sequencer_unit_test: done, errors");
    end
    $finish;
  end

endmodule
